### rtl/spsd_pkg.sv
// ----------------------------------------------------------------------------
// spsd_pkg: shared constants and types for the sync preamble deframer
// Frame geometry, field widths, register indexes and the phase encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spsd_pkg;

  // frame geometry
  localparam int SYNC_REPEATS = 4;    // 2..8
  localparam int RECORD_BYTES = 16;   // fixed
  localparam int MAX_LINE_LEN = 256;  // 1..511

  localparam int SEEN_W  = $clog2(SYNC_REPEATS);
  localparam int COUNT_W = 9;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int HOLD_W  = (RECORD_BYTES - 1) * BYTE_W;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_RECORD_SYNC = 2'd0,
    REG_TEXT_SYNC   = 2'd1,
    REG_LINE_TERM   = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  localparam logic [BYTE_W-1:0] RECORD_SYNC_RST = 8'h11;
  localparam logic [BYTE_W-1:0] TEXT_SYNC_RST   = 8'h22;
  localparam logic [BYTE_W-1:0] LINE_TERM_RST   = 8'h0A;

  // result kind
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_TEXT   = 1'b1;

  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_RSYNC = 5'b00010,
    PH_TSYNC = 5'b00100,
    PH_RPAY  = 5'b01000,
    PH_TEXT  = 5'b10000
  } phase_t;

endpackage

### rtl/sync_preamble_serial_deframer.sv
// ----------------------------------------------------------------------------
// sync_preamble_serial_deframer: serial byte stream deframer
// Takes one received byte per transaction. SYNC_REPEATS back-to-back copies of
// the record sync byte open a 16-byte little-endian record (32-bit ms stamp
// and three raw IEEE single words), delivered as one result transaction when
// its last byte arrives. SYNC_REPEATS copies of the text sync byte open a text
// line whose bytes are delivered one per transaction, text_last marking the
// terminator (which is delivered) or the byte that reaches MAX_LINE_LEN. A byte
// that breaks a preamble is dropped and hunting resumes; bytes between frames
// are ignored. Fields not used by a result kind read as zero. Rate: one input
// transaction per clock, sustained; a result enters the output register in the
// cycle after the byte that causes it is taken, and the input stalls only while
// that register holds a result the sink has not yet taken. Registers sit on an
// APB-style port at byte addresses 0, 4 and 8; write them only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_preamble_serial_deframer (
  input  logic                              clk,
  input  logic                              rst,
  // APB-style configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spsd_pkg::ADDR_W-1:0]       paddr,
  input  logic [spsd_pkg::DATA_W-1:0]       pwdata,
  output logic [spsd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  // byte input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        rx_byte,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              rec_kind,
  output logic [31:0]                       stamp_ms,
  output logic [31:0]                       accel_x_bits,
  output logic [31:0]                       accel_y_bits,
  output logic [31:0]                       accel_z_bits,
  output logic [7:0]                        text_char,
  output logic                              text_last
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [spsd_pkg::BYTE_W-1:0] record_sync;
  logic [spsd_pkg::BYTE_W-1:0] text_sync;
  logic [spsd_pkg::BYTE_W-1:0] line_term;

  spsd_pkg::reg_idx_t reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = spsd_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_sync <= spsd_pkg::RECORD_SYNC_RST;
      text_sync   <= spsd_pkg::TEXT_SYNC_RST;
      line_term   <= spsd_pkg::LINE_TERM_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        spsd_pkg::REG_RECORD_SYNC: record_sync <= pwdata[7:0];
        spsd_pkg::REG_TEXT_SYNC:   text_sync   <= pwdata[7:0];
        spsd_pkg::REG_LINE_TERM:   line_term   <= pwdata[7:0];
        default: ; // unmapped address, write dropped
      endcase
    end
  end

  // readback, zero-extended
  always_comb begin
    unique case (reg_idx)
      spsd_pkg::REG_RECORD_SYNC: prdata = {24'd0, record_sync};
      spsd_pkg::REG_TEXT_SYNC:   prdata = {24'd0, text_sync};
      spsd_pkg::REG_LINE_TERM:   prdata = {24'd0, line_term};
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: a byte is taken whenever the output register is free or is
  // being emptied this cycle, so the stream runs at one byte per clock unless a held result is stalled.
  // --------------------------------------------------------------------------
  logic in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Framing state
  // --------------------------------------------------------------------------
  spsd_pkg::phase_t               phase, phase_next;
  logic [spsd_pkg::SEEN_W-1:0]    sync_seen, sync_seen_next;
  logic [spsd_pkg::COUNT_W-1:0]   payload_count, payload_count_next;
  // first RECORD_BYTES-1 record bytes; newest enters at the top, so after
  // a full record the oldest byte sits in the low byte lane
  logic [spsd_pkg::HOLD_W-1:0]    hold;

  logic [spsd_pkg::COUNT_W-1:0]   count_inc;
  logic [spsd_pkg::BYTE_W-1:0]    want;
  logic                           seen_full;
  logic                           rec_done;
  logic                           line_end;
  logic [spsd_pkg::RECORD_BYTES*spsd_pkg::BYTE_W-1:0] rec_bits;

  // result being formed for the output register
  logic                           res_fire;
  logic                           res_kind;
  logic                           res_last;

  assign count_inc = payload_count + spsd_pkg::COUNT_W'(1);
  assign want      = (phase == spsd_pkg::PH_RSYNC) ? record_sync : text_sync;
  assign seen_full = (sync_seen == spsd_pkg::SEEN_W'(spsd_pkg::SYNC_REPEATS - 1));
  assign rec_done  = (payload_count ==
                      spsd_pkg::COUNT_W'(spsd_pkg::RECORD_BYTES - 1));
  assign line_end  = (rx_byte == line_term) ||
                     (count_inc >= spsd_pkg::COUNT_W'(spsd_pkg::MAX_LINE_LEN));
  assign rec_bits  = {rx_byte, hold};

  always_comb begin
    phase_next         = phase;
    sync_seen_next     = sync_seen;
    payload_count_next = payload_count;
    res_fire           = 1'b0;
    res_kind           = spsd_pkg::KIND_RECORD;
    res_last           = 1'b0;

    unique case (phase) inside
      spsd_pkg::PH_HUNT: begin
        // record sync wins when both sync registers match
        if (rx_byte == record_sync) begin
          phase_next     = spsd_pkg::PH_RSYNC;
          sync_seen_next = spsd_pkg::SEEN_W'(1);
        end else if (rx_byte == text_sync) begin
          phase_next     = spsd_pkg::PH_TSYNC;
          sync_seen_next = spsd_pkg::SEEN_W'(1);
        end
      end

      spsd_pkg::PH_RSYNC, spsd_pkg::PH_TSYNC: begin
        if (rx_byte != want) begin
          // broken preamble: this byte is dropped, not re-hunted
          phase_next     = spsd_pkg::PH_HUNT;
          sync_seen_next = '0;
        end else if (seen_full) begin
          sync_seen_next     = '0;
          payload_count_next = '0;
          if (phase == spsd_pkg::PH_RSYNC) begin
            phase_next = spsd_pkg::PH_RPAY;
          end else if (text_sync == line_term) begin
            // line already ended by its own preamble
            phase_next = spsd_pkg::PH_HUNT;
          end else begin
            phase_next = spsd_pkg::PH_TEXT;
          end
        end else begin
          sync_seen_next = sync_seen + spsd_pkg::SEEN_W'(1);
        end
      end

      spsd_pkg::PH_RPAY: begin
        if (rec_done) begin
          res_fire           = 1'b1;
          res_kind           = spsd_pkg::KIND_RECORD;
          phase_next         = spsd_pkg::PH_HUNT;
          payload_count_next = '0;
        end else begin
          payload_count_next = count_inc;
        end
      end

      spsd_pkg::PH_TEXT: begin
        res_fire           = 1'b1;
        res_kind           = spsd_pkg::KIND_TEXT;
        res_last           = line_end;
        payload_count_next = count_inc;
        if (line_end) begin
          phase_next         = spsd_pkg::PH_HUNT;
          payload_count_next = '0;
        end
      end

      default: begin
        phase_next         = spsd_pkg::PH_HUNT;
        sync_seen_next     = '0;
        payload_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= spsd_pkg::PH_HUNT;
      sync_seen     <= '0;
      payload_count <= '0;
    end else if (in_accept) begin
      phase         <= phase_next;
      sync_seen     <= sync_seen_next;
      payload_count <= payload_count_next;
    end
  end

  // record byte hold line, no reset needed: every lane is filled before use
  always_ff @(posedge clk) begin
    if (in_accept && (phase == spsd_pkg::PH_RPAY) && !rec_done) begin
      hold <= {rx_byte, hold[spsd_pkg::HOLD_W-1:spsd_pkg::BYTE_W]};
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_fire;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_fire) begin
      rec_kind <= res_kind;
      if (res_kind == spsd_pkg::KIND_RECORD) begin
        stamp_ms     <= rec_bits[31:0];
        accel_x_bits <= rec_bits[63:32];
        accel_y_bits <= rec_bits[95:64];
        accel_z_bits <= rec_bits[127:96];
        text_char    <= '0;
        text_last    <= 1'b0;
      end else begin
        stamp_ms     <= '0;
        accel_x_bits <= '0;
        accel_y_bits <= '0;
        accel_z_bits <= '0;
        text_char    <= rx_byte;
        text_last    <= res_last;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_hunt_no_seen: assert property (@(posedge clk) disable iff (rst)
    (phase == spsd_pkg::PH_HUNT) |-> (sync_seen == '0))
    else $error("sync count not cleared while hunting");

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == spsd_pkg::PH_TEXT) |->
      (payload_count < spsd_pkg::COUNT_W'(spsd_pkg::MAX_LINE_LEN)))
    else $error("text line ran past its length limit");

  a_record_out: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (phase == spsd_pkg::PH_RPAY) && rec_done) |=>
      (out_valid && (rec_kind == spsd_pkg::KIND_RECORD) &&
       (phase == spsd_pkg::PH_HUNT)))
    else $error("completed record not delivered");

  a_last_is_text: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_last) |-> (rec_kind == spsd_pkg::KIND_TEXT))
    else $error("line end flagged on a record");
`endif

endmodule
